// ===== sv/bpf_pkg.sv =====
// shared types, constants and helper functions for the buckingham pair force block
`timescale 1ns / 1ps
`default_nettype none
package bpf_pkg;

    localparam int FRAC = 24;
    localparam logic [63:0] CAP = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] L2E = 64'h0000_0001_7154_7653;
    localparam logic [63:0] LN2 = 64'h0000_0000_B172_17F8;
    localparam logic [24:0] ONE = 25'(1) << FRAC;

    typedef struct packed {
        logic [39:0]        cutoff_sq;
        logic [47:0]        rho_inverse;
        logic [47:0]        force_exp_coef;
        logic [47:0]        force_disp_coef;
        logic [47:0]        energy_exp_coef;
        logic [47:0]        energy_disp_coef;
        logic signed [47:0] energy_offset;
        logic               energy_enable;
    } cfg_t;

    typedef enum logic [3:0] {
        MOP_R2SQ,
        MOP_R6,
        MOP_T,
        MOP_U,
        MOP_X,
        MOP_B1R,
        MOP_B1E,
        MOP_B2,
        MOP_FS,
        MOP_FP,
        MOP_FX,
        MOP_FY,
        MOP_FZ,
        MOP_EA,
        MOP_EC,
        MOP_ES
    } mop_t;

    typedef struct packed {
        logic       load;
        logic       sq_step;
        logic       root_step;
        logic       mul_start;
        logic       mul_wr;
        logic       ser_step;
        logic       exp_fin;
        logic       capture;
        mop_t       mop;
        logic [5:0] cnt;
        logic [1:0] phase;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic mul_done;
    } stat_t;

    function automatic logic [55:0] sat56(input logic signed [63:0] v);
        logic [55:0] res;
        if (!v[63] && (|v[62:55]))
        begin
            res = {1'b0, {55{1'b1}}};
        end
        else if (v[63] && !(&v[62:55]))
        begin
            res = {1'b1, 55'b0};
        end
        else
        begin
            res = v[55:0];
        end
        return res;
    endfunction

    function automatic logic [55:0] add_sat56(input logic [55:0] a, input logic [55:0] b);
        logic [56:0] s;
        logic [55:0] res;
        s = {a[55], a} + {b[55], b};
        if (s[56] != s[55])
        begin
            res = s[56] ? {1'b1, 55'b0} : {1'b0, {55{1'b1}}};
        end
        else
        begin
            res = s[55:0];
        end
        return res;
    endfunction

    // ceil(2^32 / k)
    function automatic logic [32:0] recip_k(input logic [4:0] k);
        logic [32:0] res;
        case (k)
            5'd1:    res = 33'h1_0000_0000;
            5'd2:    res = 33'h0_8000_0000;
            5'd3:    res = 33'h0_5555_5556;
            5'd4:    res = 33'h0_4000_0000;
            5'd5:    res = 33'h0_3333_3334;
            5'd6:    res = 33'h0_2AAA_AAAB;
            5'd7:    res = 33'h0_2492_4925;
            5'd8:    res = 33'h0_2000_0000;
            5'd9:    res = 33'h0_1C71_C71D;
            5'd10:   res = 33'h0_1999_999A;
            5'd11:   res = 33'h0_1745_D175;
            5'd12:   res = 33'h0_1555_5556;
            5'd13:   res = 33'h0_13B1_3B14;
            5'd14:   res = 33'h0_1249_2493;
            5'd15:   res = 33'h0_1111_1112;
            5'd16:   res = 33'h0_1000_0000;
            default: res = 33'h1_0000_0000;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== sv/buckingham_pair_force_top.sv =====
// buckingham pair force block, top level
//
// one neighbor pair enters per item on the pair channel (pair_valid/pair_ready)
// with its displacement dx/dy/dz, scale factor and last_neighbor mark; one result
// item leaves on the result channel (result_valid/result_ready) with the pair
// force, pair energy, cutoff flag and, on the last neighbor, the summed force of
// the central atom. coefficients are set through the apb-style port; the user
// must write them only while idle, the block itself does not enforce it.
// items are worked one at a time; the work per in-range item is the 49-step
// root/reciprocal iteration, the exponential series and 13 to 16 products on
// the single shared multiplier. the finished item sits in the output register,
// so the next item is taken while it waits; a stalled receiver holds the block
// only when a second result is ready to be written.
// reset clears the configuration and control registers, the force sums and both
// channels; result_valid is low.
`timescale 1ns / 1ps
`default_nettype none
module buckingham_pair_force_top
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [5:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic [63:0]             prdata,
    output logic                    pready,
    input  wire logic               pair_valid,
    output logic                    pair_ready,
    input  wire logic signed [31:0] dx,
    input  wire logic signed [31:0] dy,
    input  wire logic signed [31:0] dz,
    input  wire logic [24:0]        special_factor,
    input  wire logic               last_neighbor,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output logic signed [55:0]      pair_fx,
    output logic signed [55:0]      pair_fy,
    output logic signed [55:0]      pair_fz,
    output logic signed [55:0]      pair_energy,
    output logic                    within_cutoff,
    output logic signed [55:0]      atom_fx,
    output logic signed [55:0]      atom_fy,
    output logic signed [55:0]      atom_fz,
    output logic                    last_out
);

    bpf_pkg::cfg_t  cfg;
    bpf_pkg::cmd_t  cmd;
    bpf_pkg::stat_t stat;

    bpf_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bpf_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .pair_valid    (pair_valid),
        .pair_ready    (pair_ready),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .energy_enable (cfg.energy_enable),
        .stat          (stat),
        .cmd           (cmd)
    );

    bpf_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg            (cfg),
        .dx             (dx),
        .dy             (dy),
        .dz             (dz),
        .special_factor (special_factor),
        .last_neighbor  (last_neighbor),
        .pair_fx        (pair_fx),
        .pair_fy        (pair_fy),
        .pair_fz        (pair_fz),
        .pair_energy    (pair_energy),
        .within_cutoff  (within_cutoff),
        .atom_fx        (atom_fx),
        .atom_fy        (atom_fy),
        .atom_fz        (atom_fz),
        .last_out       (last_out)
    );

endmodule
`default_nettype wire

// ===== sv/bpf_regs.sv =====
// configuration register file behind the apb-style port
`timescale 1ns / 1ps
`default_nettype none
module bpf_regs
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output bpf_pkg::cfg_t     cfg
);

    localparam logic [2:0] REG_CUTOFF   = 3'd0;
    localparam logic [2:0] REG_RHO_INV  = 3'd1;
    localparam logic [2:0] REG_F_EXP    = 3'd2;
    localparam logic [2:0] REG_F_DISP   = 3'd3;
    localparam logic [2:0] REG_E_EXP    = 3'd4;
    localparam logic [2:0] REG_E_DISP   = 3'd5;
    localparam logic [2:0] REG_E_OFFSET = 3'd6;
    localparam logic [2:0] REG_E_ENABLE = 3'd7;

    bpf_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[5:3])
                REG_CUTOFF:   cfg_reg.cutoff_sq        <= pwdata[39:0];
                REG_RHO_INV:  cfg_reg.rho_inverse      <= pwdata[47:0];
                REG_F_EXP:    cfg_reg.force_exp_coef   <= pwdata[47:0];
                REG_F_DISP:   cfg_reg.force_disp_coef  <= pwdata[47:0];
                REG_E_EXP:    cfg_reg.energy_exp_coef  <= pwdata[47:0];
                REG_E_DISP:   cfg_reg.energy_disp_coef <= pwdata[47:0];
                REG_E_OFFSET: cfg_reg.energy_offset    <= pwdata[47:0];
                REG_E_ENABLE: cfg_reg.energy_enable    <= pwdata[0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            REG_CUTOFF:   prdata = {24'b0, cfg_reg.cutoff_sq};
            REG_RHO_INV:  prdata = {16'b0, cfg_reg.rho_inverse};
            REG_F_EXP:    prdata = {16'b0, cfg_reg.force_exp_coef};
            REG_F_DISP:   prdata = {16'b0, cfg_reg.force_disp_coef};
            REG_E_EXP:    prdata = {16'b0, cfg_reg.energy_exp_coef};
            REG_E_DISP:   prdata = {16'b0, cfg_reg.energy_disp_coef};
            REG_E_OFFSET: prdata = {{16{cfg_reg.energy_offset[47]}}, cfg_reg.energy_offset};
            REG_E_ENABLE: prdata = {63'b0, cfg_reg.energy_enable};
            default:      prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/bpf_mul.sv =====
// shared 64x64 fixed point multiplier, four 32x32 partial products, capped and signed
`timescale 1ns / 1ps
`default_nettype none
module bpf_mul
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [63:0] a,
    input  wire logic signed [63:0] b,
    input  wire logic               shift32,
    output logic                    done,
    output logic signed [63:0]      res
);

    logic         busy_reg;
    logic [2:0]   ph_reg;
    logic         done_reg;
    logic [63:0]  am_reg;
    logic [63:0]  bm_reg;
    logic         neg_reg;
    logic         s32_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pps_reg;
    logic [127:0] acc_reg;
    logic signed [63:0] res_reg;

    logic [31:0]  pa;
    logic [31:0]  pb;
    logic [127:0] pp_shift;
    logic         cap_hit;
    logic [63:0]  mag;

    assign done = done_reg;
    assign res  = res_reg;

    always_comb
    begin
        pa = ph_reg[1] ? am_reg[63:32] : am_reg[31:0];
        pb = ph_reg[0] ? bm_reg[63:32] : bm_reg[31:0];
        case (pps_reg)
            2'd0:    pp_shift = {64'b0, pp_reg};
            2'd3:    pp_shift = {pp_reg, 64'b0};
            default: pp_shift = {32'b0, pp_reg, 32'b0};
        endcase
        if (s32_reg)
        begin
            cap_hit = |acc_reg[127:94];
            mag     = cap_hit ? bpf_pkg::CAP : {2'b0, acc_reg[93:32]};
        end
        else
        begin
            cap_hit = |acc_reg[127:bpf_pkg::FRAC + 62];
            mag     = cap_hit ? bpf_pkg::CAP
                              : {2'b0, acc_reg[bpf_pkg::FRAC + 61:bpf_pkg::FRAC]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ph_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                ph_reg   <= '0;
            end
            else if (busy_reg)
            begin
                ph_reg <= ph_reg + 3'd1;
                if (ph_reg == 3'd5)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            am_reg  <= a[63] ? 64'(-a) : 64'(a);
            bm_reg  <= b[63] ? 64'(-b) : 64'(b);
            neg_reg <= a[63] ^ b[63];
            s32_reg <= shift32;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ph_reg <= 3'd3)
            begin
                pp_reg  <= 64'(pa) * 64'(pb);
                pps_reg <= ph_reg[1:0];
            end
            if (ph_reg >= 3'd1 && ph_reg <= 3'd4)
            begin
                acc_reg <= acc_reg + pp_shift;
            end
            if (ph_reg == 3'd5)
            begin
                res_reg <= neg_reg ? -$signed(mag) : $signed(mag);
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/bpf_dp.sv =====
// datapath: squares, root and reciprocal iteration, exponential series, products, sums
`timescale 1ns / 1ps
`default_nettype none
module bpf_dp
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bpf_pkg::cmd_t      cmd,
    output bpf_pkg::stat_t          stat,
    input  wire bpf_pkg::cfg_t      cfg,
    input  wire logic signed [31:0] dx,
    input  wire logic signed [31:0] dy,
    input  wire logic signed [31:0] dz,
    input  wire logic [24:0]        special_factor,
    input  wire logic               last_neighbor,
    output logic signed [55:0]      pair_fx,
    output logic signed [55:0]      pair_fy,
    output logic signed [55:0]      pair_fz,
    output logic signed [55:0]      pair_energy,
    output logic                    within_cutoff,
    output logic signed [55:0]      atom_fx,
    output logic signed [55:0]      atom_fy,
    output logic signed [55:0]      atom_fz,
    output logic                    last_out
);

    logic signed [31:0] d_reg [3];
    logic [24:0]        scale_reg;
    logic               last_reg;
    logic [63:0]        rsq_reg;
    logic [63:0]        sqp_reg;
    logic [63:0]        sv_reg;
    logic [63:0]        sres_reg;
    logic [39:0]        rem_reg;
    logic [48:0]        quo_reg;
    logic signed [63:0] ta_reg;
    logic signed [63:0] tb_reg;
    logic signed [63:0] tc_reg;
    logic signed [63:0] r6inv_reg;
    logic signed [63:0] t_reg;
    logic signed [63:0] u_reg;
    logic [23:0]        x_reg;
    logic signed [63:0] fpair_reg;
    logic [55:0]        f_reg [3];
    logic [55:0]        en_reg;
    logic [24:0]        term_reg;
    logic signed [26:0] sacc_reg;
    logic [47:0]        sp_reg;
    logic [56:0]        sq_reg;
    logic [24:0]        rexp_reg;
    logic [55:0]        sum_reg [3];
    logic [55:0]        pf_reg [3];
    logic [55:0]        pe_reg;
    logic               wc_reg;
    logic [55:0]        af_reg [3];
    logic               lo_reg;

    logic               hit;
    logic [39:0]        dsq;
    logic [63:0]        r2inv;
    logic [31:0]        mag_sel;
    logic [63:0]        bitv;
    logic [5:0]         bsh;
    logic [63:0]        trial;
    logic [40:0]        rem_sh;
    logic [48:0]        sprod;
    logic [56:0]        qprod;
    logic [24:0]        term_new;
    logic [24:0]        clampv;
    logic signed [63:0] op_a;
    logic signed [63:0] op_b;
    logic               op_s32;
    logic               mul_done;
    logic signed [63:0] mul_res;
    logic [55:0]        nsum [3];

    assign dsq   = rsq_reg[63:bpf_pkg::FRAC];
    assign hit   = (rsq_reg != 64'b0) && (dsq < cfg.cutoff_sq);
    assign r2inv = (dsq == 40'b0) ? bpf_pkg::CAP : {15'b0, quo_reg};

    assign stat.hit      = hit;
    assign stat.mul_done = mul_done;

    always_comb
    begin
        case (cmd.cnt[1:0])
            2'd0:    mag_sel = d_reg[0][31] ? 32'(-d_reg[0]) : 32'(d_reg[0]);
            2'd1:    mag_sel = d_reg[1][31] ? 32'(-d_reg[1]) : 32'(d_reg[1]);
            default: mag_sel = d_reg[2][31] ? 32'(-d_reg[2]) : 32'(d_reg[2]);
        endcase
        bsh      = 6'd62 - {cmd.cnt[4:0], 1'b0};
        bitv     = 64'(1) << bsh;
        trial    = sres_reg + bitv;
        rem_sh   = {rem_reg, (cmd.cnt == 6'd0)};
        sprod    = 49'(term_reg) * 49'(x_reg);
        qprod    = 57'(sp_reg[47:24]) * 57'(bpf_pkg::recip_k(cmd.cnt[4:0]));
        term_new = sq_reg[56:32];
        if (sacc_reg < 0)
        begin
            clampv = '0;
        end
        else if (sacc_reg > 27'(bpf_pkg::ONE))
        begin
            clampv = bpf_pkg::ONE;
        end
        else
        begin
            clampv = sacc_reg[24:0];
        end
        for (int i = 0; i < 3; i++)
        begin
            nsum[i] = hit ? bpf_pkg::add_sat56(sum_reg[i], f_reg[i]) : sum_reg[i];
        end
    end

    always_comb
    begin
        op_s32 = 1'b0;
        case (cmd.mop)
            bpf_pkg::MOP_R2SQ:
            begin
                op_a = r2inv;
                op_b = r2inv;
            end
            bpf_pkg::MOP_R6:
            begin
                op_a = ta_reg;
                op_b = r2inv;
            end
            bpf_pkg::MOP_T:
            begin
                op_a = sres_reg;
                op_b = {16'b0, cfg.rho_inverse};
            end
            bpf_pkg::MOP_U:
            begin
                op_a   = t_reg;
                op_b   = bpf_pkg::L2E;
                op_s32 = 1'b1;
            end
            bpf_pkg::MOP_X:
            begin
                op_a   = {40'b0, u_reg[23:0]};
                op_b   = bpf_pkg::LN2;
                op_s32 = 1'b1;
            end
            bpf_pkg::MOP_B1R:
            begin
                op_a = {16'b0, cfg.force_exp_coef};
                op_b = sres_reg;
            end
            bpf_pkg::MOP_B1E:
            begin
                op_a = ta_reg;
                op_b = {39'b0, rexp_reg};
            end
            bpf_pkg::MOP_B2:
            begin
                op_a = {16'b0, cfg.force_disp_coef};
                op_b = r6inv_reg;
            end
            bpf_pkg::MOP_FS:
            begin
                op_a = tb_reg - tc_reg;
                op_b = {39'b0, scale_reg};
            end
            bpf_pkg::MOP_FP:
            begin
                op_a = ta_reg;
                op_b = r2inv;
            end
            bpf_pkg::MOP_FX:
            begin
                op_a = {{32{d_reg[0][31]}}, d_reg[0]};
                op_b = fpair_reg;
            end
            bpf_pkg::MOP_FY:
            begin
                op_a = {{32{d_reg[1][31]}}, d_reg[1]};
                op_b = fpair_reg;
            end
            bpf_pkg::MOP_FZ:
            begin
                op_a = {{32{d_reg[2][31]}}, d_reg[2]};
                op_b = fpair_reg;
            end
            bpf_pkg::MOP_EA:
            begin
                op_a = {16'b0, cfg.energy_exp_coef};
                op_b = {39'b0, rexp_reg};
            end
            bpf_pkg::MOP_EC:
            begin
                op_a = {16'b0, cfg.energy_disp_coef};
                op_b = r6inv_reg;
            end
            bpf_pkg::MOP_ES:
            begin
                op_a = tb_reg - tc_reg - {{16{cfg.energy_offset[47]}}, cfg.energy_offset};
                op_b = {39'b0, scale_reg};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    bpf_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (op_a),
        .b       (op_b),
        .shift32 (op_s32),
        .done    (mul_done),
        .res     (mul_res)
    );

    // running force sums for the central atom
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else if (cmd.capture)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= last_reg ? 56'b0 : nsum[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            d_reg[0]  <= dx;
            d_reg[1]  <= dy;
            d_reg[2]  <= dz;
            scale_reg <= special_factor;
            last_reg  <= last_neighbor;
            rsq_reg   <= '0;
            sres_reg  <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            term_reg  <= bpf_pkg::ONE;
            sacc_reg  <= 27'(bpf_pkg::ONE);
        end
        if (cmd.sq_step)
        begin
            if (cmd.cnt != 6'd0)
            begin
                rsq_reg <= rsq_reg + sqp_reg;
            end
            sqp_reg <= 64'(mag_sel) * 64'(mag_sel);
            sv_reg  <= rsq_reg + sqp_reg;
        end
        if (cmd.root_step)
        begin
            if (cmd.cnt < 6'd32)
            begin
                if (sv_reg >= trial)
                begin
                    sv_reg   <= sv_reg - trial;
                    sres_reg <= (sres_reg >> 1) + bitv;
                end
                else
                begin
                    sres_reg <= sres_reg >> 1;
                end
            end
            if (rem_sh >= {1'b0, dsq})
            begin
                rem_reg <= 40'(rem_sh - {1'b0, dsq});
                quo_reg <= {quo_reg[47:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[39:0];
                quo_reg <= {quo_reg[47:0], 1'b0};
            end
        end
        if (cmd.ser_step)
        begin
            case (cmd.phase)
                2'd0:    sp_reg <= sprod[47:0];
                2'd1:    sq_reg <= qprod;
                default:
                begin
                    term_reg <= term_new;
                    sacc_reg <= cmd.cnt[0] ? sacc_reg - 27'(term_new)
                                           : sacc_reg + 27'(term_new);
                end
            endcase
        end
        if (cmd.exp_fin)
        begin
            rexp_reg <= (|u_reg[61:30]) ? 25'b0 : clampv >> u_reg[29:24];
        end
        if (cmd.mul_wr)
        begin
            case (cmd.mop)
                bpf_pkg::MOP_R2SQ: ta_reg    <= mul_res;
                bpf_pkg::MOP_R6:   r6inv_reg <= mul_res;
                bpf_pkg::MOP_T:    t_reg     <= mul_res;
                bpf_pkg::MOP_U:    u_reg     <= mul_res;
                bpf_pkg::MOP_X:    x_reg     <= mul_res[23:0];
                bpf_pkg::MOP_B1R:  ta_reg    <= mul_res;
                bpf_pkg::MOP_B1E:  tb_reg    <= mul_res;
                bpf_pkg::MOP_B2:   tc_reg    <= mul_res;
                bpf_pkg::MOP_FS:   ta_reg    <= mul_res;
                bpf_pkg::MOP_FP:   fpair_reg <= mul_res;
                bpf_pkg::MOP_FX:   f_reg[0]  <= bpf_pkg::sat56(mul_res);
                bpf_pkg::MOP_FY:   f_reg[1]  <= bpf_pkg::sat56(mul_res);
                bpf_pkg::MOP_FZ:   f_reg[2]  <= bpf_pkg::sat56(mul_res);
                bpf_pkg::MOP_EA:   tb_reg    <= mul_res;
                bpf_pkg::MOP_EC:   tc_reg    <= mul_res;
                bpf_pkg::MOP_ES:   en_reg    <= bpf_pkg::sat56(mul_res);
                default:           en_reg    <= en_reg;
            endcase
        end
        if (cmd.capture)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pf_reg[i] <= hit ? f_reg[i] : 56'b0;
                af_reg[i] <= last_reg ? nsum[i] : 56'b0;
            end
            pe_reg <= (hit && cfg.energy_enable) ? en_reg : 56'b0;
            wc_reg <= hit;
            lo_reg <= last_reg;
        end
    end

    assign pair_fx       = pf_reg[0];
    assign pair_fy       = pf_reg[1];
    assign pair_fz       = pf_reg[2];
    assign pair_energy   = pe_reg;
    assign within_cutoff = wc_reg;
    assign atom_fx       = af_reg[0];
    assign atom_fy       = af_reg[1];
    assign atom_fz       = af_reg[2];
    assign last_out      = lo_reg;

endmodule
`default_nettype wire

// ===== sv/bpf_ctrl.sv =====
// controller state machine sequencing the datapath for one item at a time
`timescale 1ns / 1ps
`default_nettype none
module bpf_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           pair_valid,
    output logic                pair_ready,
    output logic                result_valid,
    input  wire logic           result_ready,
    input  wire logic           energy_enable,
    input  wire bpf_pkg::stat_t stat,
    output bpf_pkg::cmd_t       cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_CHK,
        ST_ROOT,
        ST_MUL,
        ST_MWAIT,
        ST_SER,
        ST_EXPF,
        ST_CAP
    } state_t;

    state_t         state_reg;
    logic [5:0]     cnt_reg;
    logic [1:0]     phase_reg;
    bpf_pkg::mop_t  mop_reg;
    logic           out_valid_reg;
    logic           cap_ok;

    assign cap_ok       = (state_reg == ST_CAP) && (!out_valid_reg || result_ready);
    assign pair_ready   = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.mop       = mop_reg;
        cmd.cnt       = cnt_reg;
        cmd.phase     = phase_reg;
        cmd.load      = (state_reg == ST_IDLE) && pair_valid;
        cmd.sq_step   = (state_reg == ST_SQ);
        cmd.root_step = (state_reg == ST_ROOT);
        cmd.mul_start = (state_reg == ST_MUL);
        cmd.mul_wr    = (state_reg == ST_MWAIT) && stat.mul_done;
        cmd.ser_step  = (state_reg == ST_SER);
        cmd.exp_fin   = (state_reg == ST_EXPF);
        cmd.capture   = cap_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            phase_reg     <= '0;
            mop_reg       <= bpf_pkg::MOP_R2SQ;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cap_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pair_valid)
                    begin
                        state_reg <= ST_SQ;
                        cnt_reg   <= '0;
                    end
                end
                ST_SQ:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd3)
                    begin
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK:
                begin
                    cnt_reg   <= '0;
                    state_reg <= stat.hit ? ST_ROOT : ST_CAP;
                end
                ST_ROOT:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd48)
                    begin
                        state_reg <= ST_MUL;
                        mop_reg   <= bpf_pkg::MOP_R2SQ;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_MWAIT;
                end
                ST_MWAIT:
                begin
                    if (stat.mul_done)
                    begin
                        case (mop_reg)
                            bpf_pkg::MOP_X:
                            begin
                                state_reg <= ST_SER;
                                cnt_reg   <= 6'd1;
                                phase_reg <= '0;
                            end
                            bpf_pkg::MOP_FZ:
                            begin
                                if (energy_enable)
                                begin
                                    state_reg <= ST_MUL;
                                    mop_reg   <= bpf_pkg::MOP_EA;
                                end
                                else
                                begin
                                    state_reg <= ST_CAP;
                                end
                            end
                            bpf_pkg::MOP_ES:
                            begin
                                state_reg <= ST_CAP;
                            end
                            default:
                            begin
                                state_reg <= ST_MUL;
                                mop_reg   <= bpf_pkg::mop_t'(mop_reg + 4'd1);
                            end
                        endcase
                    end
                end
                ST_SER:
                begin
                    if (phase_reg == 2'd2)
                    begin
                        phase_reg <= '0;
                        cnt_reg   <= cnt_reg + 6'd1;
                        if (cnt_reg == 6'd16)
                        begin
                            state_reg <= ST_EXPF;
                        end
                    end
                    else
                    begin
                        phase_reg <= phase_reg + 2'd1;
                    end
                end
                ST_EXPF:
                begin
                    state_reg <= ST_MUL;
                    mop_reg   <= bpf_pkg::MOP_B1R;
                end
                ST_CAP:
                begin
                    if (cap_ok)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
